/* rtl/weighted_price_rate_moving_average_core_defines.svh */
// assertion macros for the weighted price rate moving average core
`ifndef WEIGHTED_PRICE_RATE_MOVING_AVERAGE_CORE_DEFINES_SVH
`define WEIGHTED_PRICE_RATE_MOVING_AVERAGE_CORE_DEFINES_SVH

`ifndef SYNTH
`define WPRA_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wpra assertion failed");
`define WPRA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wpra assertion failed");
`else
`define WPRA_ASSERT_IMPLY(lbl, ante, cons)
`define WPRA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/wpra_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wpra_pkg;

    localparam int MAX_WINDOW     = 64;
    localparam int RING_AW        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W          = $clog2(MAX_WINDOW + 1);
    localparam int CFG_W          = 7;
    localparam int PRICE_W        = 32;
    localparam int RATE_W         = 32;
    localparam int Q_SHIFT        = 24;
    localparam int WSUM_W         = PRICE_W + 3;
    localparam int SUM_W          = RATE_W + RING_AW;
    localparam int DIV_NW         = PRICE_W + Q_SHIFT;
    localparam int DIV_DW         = 32;
    localparam int DIV_CW         = $clog2(DIV_NW + 1);
    // reciprocal of 7 rounded up at 2^38 is a 36-bit multiplier
    localparam int RECIP_SHIFT    = 38;
    localparam int PROD_W         = WSUM_W + 36;

    localparam logic [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};

    typedef struct packed {
        logic [PRICE_W-1:0] open_price;
        logic [PRICE_W-1:0] high_price;
        logic [PRICE_W-1:0] low_price;
        logic [PRICE_W-1:0] close_price;
        logic               last_bar;
    } in_beat_t;

    typedef struct packed {
        logic [PRICE_W-1:0]       weighted_price;
        logic signed [RATE_W-1:0] price_rate;
        logic signed [RATE_W-1:0] rate_average;
        logic                     divide_fault;
        logic                     series_end;
    } out_beat_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] numer;
        logic [DIV_DW-1:0] denom;
        logic [DIV_CW-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/wpra_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module wpra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/wpra_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module wpra_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wpra_pkg::div_req_t req,
    output wpra_pkg::div_rsp_t     rsp
);

    logic [wpra_pkg::DIV_NW-1:0] nq_reg;
    logic [wpra_pkg::DIV_DW-1:0] rem_reg;
    logic [wpra_pkg::DIV_DW-1:0] den_reg;
    logic [wpra_pkg::DIV_CW-1:0] cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [wpra_pkg::DIV_DW:0]   rem_sh;
    logic [wpra_pkg::DIV_DW:0]   diff;
    logic                        take;

    // one restoring step per cycle
    always_comb
    begin
        rem_sh = {rem_reg, nq_reg[wpra_pkg::DIV_NW-1]};
        diff   = rem_sh - {1'b0, den_reg};
        take   = !diff[wpra_pkg::DIV_DW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nq_reg   <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                nq_reg   <= req.numer;
                rem_reg  <= '0;
                den_reg  <= req.denom;
                cnt_reg  <= req.steps;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                nq_reg  <= {nq_reg[wpra_pkg::DIV_NW-2:0], take};
                rem_reg <= take ? diff[wpra_pkg::DIV_DW-1:0] : rem_sh[wpra_pkg::DIV_DW-1:0];
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == wpra_pkg::DIV_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = nq_reg;

endmodule

`default_nettype wire

/* rtl/weighted_price_rate_moving_average_core.sv */
// flow from input beat to result beat: weighted price by shifted adds, rate division
//   (skipped on the first bar or a fault), memory write, ring sum over the window from
//   the rate memory, average division (skipped until full), output register
// throughput: one bar at a time, the next input beat is taken once the result is registered
// reset: asynchronous, clears the series state and sets window_length to 1; the rate memory
//   is not cleared, only entries written in the current series are read
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_price_rate_moving_average_core_defines.svh"

module weighted_price_rate_moving_average_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [wpra_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire wpra_pkg::in_beat_t               in_data,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output wpra_pkg::out_beat_t                   out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WMUL,
        S_WCHK,
        S_RDIV,
        S_WRITE,
        S_SUM,
        S_ADIV,
        S_DONE
    } state_t;

    state_t                          state_reg;
    logic [wpra_pkg::CFG_W-1:0]      window_reg;
    logic [wpra_pkg::CNT_W-1:0]      win_reg;
    logic [wpra_pkg::PRICE_W-1:0]    prev_price_reg;
    logic [wpra_pkg::CNT_W-1:0]      bars_seen_reg;
    logic [wpra_pkg::RING_AW-1:0]    slot_reg;
    logic [wpra_pkg::RING_AW-1:0]    cur_slot_reg;
    logic                            last_reg;
    logic [wpra_pkg::WSUM_W-1:0]     wx_reg;
    logic [wpra_pkg::PROD_W-1:0]     wacc_reg;
    logic [wpra_pkg::PROD_W-1:0]     wpart_reg;
    logic [2:0]                      wstep_reg;
    logic [wpra_pkg::PRICE_W-1:0]    w_reg;
    logic [wpra_pkg::RATE_W-1:0]     rate_reg;
    logic [wpra_pkg::RATE_W-1:0]     avg_reg;
    logic                            fault_reg;
    logic                            ge_reg;
    logic                            neg_reg;
    logic [wpra_pkg::CNT_W-1:0]      iss_reg;
    logic                            rd_vld_reg;
    logic [wpra_pkg::SUM_W-1:0]      acc_reg;
    wpra_pkg::div_req_t              div_req_reg;
    logic                            out_valid_reg;
    wpra_pkg::out_beat_t             out_data_reg;

    wpra_pkg::div_rsp_t              div_rsp;
    logic [wpra_pkg::RATE_W-1:0]     ring_rdata;

    logic [wpra_pkg::WSUM_W-1:0]     wsum;
    logic [wpra_pkg::CNT_W-1:0]      win_eff;
    logic [wpra_pkg::PRICE_W-1:0]    w_new;
    logic                            ge;
    logic [wpra_pkg::PRICE_W-1:0]    delta;
    logic [wpra_pkg::RATE_W-1:0]     rate_q;
    logic [wpra_pkg::RATE_W-1:0]     rate_new;
    logic [wpra_pkg::CNT_W-1:0]      bars_inc;
    logic [wpra_pkg::CNT_W:0]        addr_calc;
    logic [wpra_pkg::RING_AW-1:0]    rd_addr;
    logic [wpra_pkg::RING_AW-1:0]    slot_inc;
    logic                            sum_neg;
    logic [wpra_pkg::SUM_W-1:0]      sum_mag;
    logic [wpra_pkg::RATE_W-1:0]     avg_q;
    logic                            out_free;
    logic                            issue;

    always_comb
    begin
        wsum = (wpra_pkg::WSUM_W'(in_data.open_price) << 1)
             + wpra_pkg::WSUM_W'(in_data.high_price)
             + wpra_pkg::WSUM_W'(in_data.low_price)
             + (wpra_pkg::WSUM_W'(in_data.close_price) << 1)
             + wpra_pkg::WSUM_W'(in_data.close_price);

        if (window_reg == '0)
        begin
            win_eff = wpra_pkg::CNT_W'(1);
        end
        else if (int'(window_reg) > wpra_pkg::MAX_WINDOW)
        begin
            win_eff = wpra_pkg::CNT_W'(wpra_pkg::MAX_WINDOW);
        end
        else
        begin
            win_eff = wpra_pkg::CNT_W'(window_reg);
        end

        w_new = wacc_reg[wpra_pkg::RECIP_SHIFT +: wpra_pkg::PRICE_W];
        ge    = (w_new >= prev_price_reg);
        delta = ge ? (w_new - prev_price_reg) : (prev_price_reg - w_new);

        // rising rate saturates, falling rate stays within minus one
        rate_q = div_rsp.quot[wpra_pkg::RATE_W-1:0];
        if (ge_reg)
        begin
            rate_new = (|div_rsp.quot[wpra_pkg::DIV_NW-1:wpra_pkg::RATE_W-1])
                     ? wpra_pkg::RATE_MAX : rate_q;
        end
        else
        begin
            rate_new = ~rate_q + 1'b1;
        end

        bars_inc = (int'(bars_seen_reg) < wpra_pkg::MAX_WINDOW)
                 ? bars_seen_reg + 1'b1 : bars_seen_reg;

        // walk back from the newest slot with wrap
        if ((wpra_pkg::CNT_W+1)'(cur_slot_reg) >= (wpra_pkg::CNT_W+1)'(iss_reg))
        begin
            addr_calc = (wpra_pkg::CNT_W+1)'(cur_slot_reg) - (wpra_pkg::CNT_W+1)'(iss_reg);
        end
        else
        begin
            addr_calc = (wpra_pkg::CNT_W+1)'(cur_slot_reg)
                      + (wpra_pkg::CNT_W+1)'(wpra_pkg::MAX_WINDOW)
                      - (wpra_pkg::CNT_W+1)'(iss_reg);
        end
        rd_addr = addr_calc[wpra_pkg::RING_AW-1:0];

        slot_inc = (int'(slot_reg) == wpra_pkg::MAX_WINDOW - 1)
                 ? '0 : slot_reg + 1'b1;

        sum_neg = acc_reg[wpra_pkg::SUM_W-1];
        sum_mag = sum_neg ? (~acc_reg + 1'b1) : acc_reg;
        avg_q   = neg_reg ? (~div_rsp.quot[wpra_pkg::RATE_W-1:0] + 1'b1)
                          : div_rsp.quot[wpra_pkg::RATE_W-1:0];

        out_free = !out_valid_reg || !out_stall;
        issue    = (state_reg == S_SUM) && (iss_reg != win_reg);
    end

    wpra_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    wpra_ram #(
        .WIDTH (wpra_pkg::RATE_W),
        .DEPTH (wpra_pkg::MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (state_reg == S_WRITE),
        .waddr (slot_reg),
        .wdata (rate_reg),
        .raddr (rd_addr),
        .rdata (ring_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            window_reg     <= wpra_pkg::CFG_W'(1);
            win_reg        <= wpra_pkg::CNT_W'(1);
            prev_price_reg <= '0;
            bars_seen_reg  <= '0;
            slot_reg       <= '0;
            cur_slot_reg   <= '0;
            last_reg       <= 1'b0;
            wx_reg         <= '0;
            wacc_reg       <= '0;
            wpart_reg      <= '0;
            wstep_reg      <= '0;
            w_reg          <= '0;
            rate_reg       <= '0;
            avg_reg        <= '0;
            fault_reg      <= 1'b0;
            ge_reg         <= 1'b0;
            neg_reg        <= 1'b0;
            iss_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            acc_reg        <= '0;
            div_req_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            div_req_reg.start <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                window_reg <= cfg_data;
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        last_reg  <= in_data.last_bar;
                        win_reg   <= win_eff;
                        wx_reg    <= wsum;
                        wstep_reg <= '0;
                        state_reg <= S_WMUL;
                    end
                end
                S_WMUL:
                begin
                    // weighted sum times the rounded-up reciprocal of 7, as shifted adds
                    wstep_reg <= wstep_reg + 1'b1;
                    case (wstep_reg)
                        3'd0:
                        begin
                            wacc_reg <= wpra_pkg::PROD_W'(wx_reg)
                                      + (wpra_pkg::PROD_W'(wx_reg) << 3);
                        end
                        3'd1:
                        begin
                            wacc_reg <= wacc_reg + (wacc_reg << 6);
                        end
                        3'd2:
                        begin
                            wpart_reg <= wacc_reg;
                            wacc_reg  <= wacc_reg + (wacc_reg << 12);
                        end
                        3'd3:
                        begin
                            wacc_reg <= wacc_reg + (wpart_reg << 24);
                        end
                        default:
                        begin
                            wacc_reg  <= (wacc_reg << 2) + wpra_pkg::PROD_W'(wx_reg);
                            state_reg <= S_WCHK;
                        end
                    endcase
                end
                S_WCHK:
                begin
                    w_reg     <= w_new;
                    rate_reg  <= '0;
                    fault_reg <= 1'b0;
                    if (bars_seen_reg == '0)
                    begin
                        state_reg <= S_WRITE;
                    end
                    else if (prev_price_reg == '0)
                    begin
                        fault_reg <= 1'b1;
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        ge_reg            <= ge;
                        div_req_reg.start <= 1'b1;
                        div_req_reg.numer <= {delta, {wpra_pkg::Q_SHIFT{1'b0}}};
                        div_req_reg.denom <= prev_price_reg;
                        div_req_reg.steps <= wpra_pkg::DIV_CW'(wpra_pkg::DIV_NW);
                        state_reg         <= S_RDIV;
                    end
                end
                S_RDIV:
                begin
                    if (div_rsp.done)
                    begin
                        rate_reg  <= rate_new;
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    cur_slot_reg <= slot_reg;
                    if (last_reg)
                    begin
                        prev_price_reg <= '0;
                        bars_seen_reg  <= '0;
                        slot_reg       <= '0;
                    end
                    else
                    begin
                        prev_price_reg <= w_reg;
                        bars_seen_reg  <= bars_inc;
                        slot_reg       <= slot_inc;
                    end
                    iss_reg    <= '0;
                    rd_vld_reg <= 1'b0;
                    acc_reg    <= '0;
                    avg_reg    <= '0;
                    if (bars_inc >= win_reg)
                    begin
                        state_reg <= S_SUM;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_SUM:
                begin
                    rd_vld_reg <= issue;
                    if (issue)
                    begin
                        iss_reg <= iss_reg + 1'b1;
                    end
                    if (rd_vld_reg)
                    begin
                        acc_reg <= acc_reg
                                 + {{wpra_pkg::RING_AW{ring_rdata[wpra_pkg::RATE_W-1]}}, ring_rdata};
                    end
                    else if (!issue)
                    begin
                        neg_reg           <= sum_neg;
                        div_req_reg.start <= 1'b1;
                        div_req_reg.numer <= {sum_mag, {(wpra_pkg::DIV_NW-wpra_pkg::SUM_W){1'b0}}};
                        div_req_reg.denom <= wpra_pkg::DIV_DW'(win_reg);
                        div_req_reg.steps <= wpra_pkg::DIV_CW'(wpra_pkg::SUM_W);
                        state_reg         <= S_ADIV;
                    end
                end
                S_ADIV:
                begin
                    if (div_rsp.done)
                    begin
                        avg_reg   <= avg_q;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg               <= 1'b1;
                        out_data_reg.weighted_price <= w_reg;
                        out_data_reg.price_rate     <= rate_reg;
                        out_data_reg.rate_average   <= avg_reg;
                        out_data_reg.divide_fault   <= fault_reg;
                        out_data_reg.series_end     <= last_reg;
                        state_reg                   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `WPRA_ASSERT_IMPLY(a_div_start_idle, div_req_reg.start, !div_rsp.busy)
    `WPRA_ASSERT_IMPLY(a_div_denom_nonzero, div_req_reg.start, div_req_reg.denom != '0)
    `WPRA_ASSERT_IMPLY(a_bars_bounded, 1'b1, int'(bars_seen_reg) <= wpra_pkg::MAX_WINDOW)
    `WPRA_ASSERT_NEXT(a_series_clear, (state_reg == S_WRITE) && last_reg,
                      (bars_seen_reg == '0) && (slot_reg == '0))

endmodule

`default_nettype wire

/* sim/tb_weighted_price_rate_moving_average_core.sv */
`timescale 1ns / 1ps

module tb_weighted_price_rate_moving_average_core;

    import wpra_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 600;
    localparam int BARS_PER_PHASE = 84;
    localparam int NUM_PHASES     = 12;
    localparam logic [PRICE_W-1:0] PRICE_MAX = '1;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    in_beat_t         in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_beat_t        out_data;

    // expected-result model state
    logic [CFG_W-1:0]   window_length = 1;
    logic [PRICE_W-1:0] prev_weighted = '0;
    logic [RATE_W-1:0]  rate_hist [MAX_WINDOW];
    logic [CNT_W-1:0]   bars_seen = '0;
    logic [RING_AW-1:0] write_slot = '0;

    in_beat_t  pending_bars[$];
    out_beat_t expected_results[$];
    out_beat_t want;

    int mismatches    = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 15;
    int recv_idle_pct = 54;
    logic hold_request = 1'b0;
    logic hold_done    = 1'b0;
    int hold_left      = 0;

    int unsigned        series_left = 0;
    logic [PRICE_W-1:0] series_base = '0;

    weighted_price_rate_moving_average_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    function automatic out_beat_t advance_series(input in_beat_t bar);
        logic [63:0]              total;
        logic [63:0]              numer;
        logic [63:0]              quot;
        logic [PRICE_W-1:0]       wp;
        logic [RATE_W-1:0]        rate;
        logic [RATE_W-1:0]        avg;
        logic                     fault;
        logic [CFG_W-1:0]         win;
        logic [RING_AW-1:0]       slot;
        logic signed [RATE_W-1:0] held;
        longint                   acc;
        int                       k;
        out_beat_t                res;
        total = 2 * {32'd0, bar.open_price} + {32'd0, bar.high_price}
                + {32'd0, bar.low_price} + 3 * {32'd0, bar.close_price};
        wp    = PRICE_W'(total / 7);
        rate  = '0;
        avg   = '0;
        fault = 1'b0;
        if (bars_seen != 0) begin
            if (prev_weighted == 0) begin
                fault = 1'b1;
            end else if (wp >= prev_weighted) begin
                numer = {32'd0, wp - prev_weighted} << Q_SHIFT;
                quot  = numer / {32'd0, prev_weighted};
                rate  = (quot > 64'h7FFF_FFFF) ? RATE_MAX : quot[RATE_W-1:0];
            end else begin
                numer = {32'd0, prev_weighted - wp} << Q_SHIFT;
                quot  = numer / {32'd0, prev_weighted};
                rate  = -quot[RATE_W-1:0];
            end
        end
        if (window_length == 0)
            win = 1;
        else if (window_length > MAX_WINDOW)
            win = CFG_W'(MAX_WINDOW);
        else
            win = window_length;
        slot = write_slot;
        rate_hist[slot] = rate;
        if (bars_seen < MAX_WINDOW)
            bars_seen = bars_seen + 1;
        if (bars_seen >= win) begin
            acc = 0;
            for (k = 0; k < win; k++) begin
                held = rate_hist[RING_AW'(slot - k)];
                acc += held;
            end
            avg = RATE_W'(acc / longint'(win));
        end
        write_slot    = slot + 1;
        prev_weighted = wp;
        res.weighted_price = wp;
        res.price_rate     = rate;
        res.rate_average   = avg;
        res.divide_fault   = fault;
        res.series_end     = bar.last_bar;
        if (bar.last_bar) begin
            prev_weighted = '0;
            bars_seen     = '0;
            write_slot    = '0;
        end
        return res;
    endfunction

    task automatic push_bar(input logic [PRICE_W-1:0] o, input logic [PRICE_W-1:0] h,
                            input logic [PRICE_W-1:0] l, input logic [PRICE_W-1:0] c,
                            input logic last);
        in_beat_t bar;
        bar.open_price  = o;
        bar.high_price  = h;
        bar.low_price   = l;
        bar.close_price = c;
        bar.last_bar    = last;
        pending_bars.push_back(bar);
    endtask

    task automatic queue_random_bar();
        int unsigned        mode;
        logic [PRICE_W-1:0] spread;
        logic [PRICE_W-1:0] f [4];
        int                 i;
        if (series_left == 0) begin
            series_left = ($urandom_range(99) < 25) ? $urandom_range(140, 65)
                                                    : $urandom_range(12, 1);
            series_base = $urandom >> $urandom_range(20, 0);
        end
        mode = $urandom_range(99);
        for (i = 0; i < 4; i++) begin
            if (mode < 65) begin
                spread = (series_base >> $urandom_range(8, 2)) + 1;
                f[i]   = series_base + $urandom_range(spread);
            end else if (mode < 73) begin
                f[i] = (i == 1 || i == 2) ? $urandom_range(2) : 0;
            end else if (mode < 81) begin
                f[i] = $urandom;
            end else if (mode < 89) begin
                f[i] = $urandom_range(15);
            end else if (mode < 95) begin
                f[i] = PRICE_MAX;
            end else begin
                f[i] = $urandom_range(1) ? PRICE_MAX : '0;
            end
        end
        if (mode < 65) begin
            spread      = (series_base >> 4) + 1;
            series_base = series_base + $urandom_range(spread) - (spread >> 1);
        end
        push_bar(f[0], f[1], f[2], f[3], series_left == 1);
        series_left--;
    endtask

    task automatic wait_idle();
        while (pending_bars.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        window_length = value;
        cfg_valid <= 1'b0;
    endtask

    // sender: a beat once raised stays until taken
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid)
                expected_results.push_back(advance_series(in_data));
            if (pending_bars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_data  <= pending_bars.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing outstanding");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_data.weighted_price !== want.weighted_price) begin
                        $error("weighted_price: expected %h, got %h",
                               want.weighted_price, out_data.weighted_price);
                        mismatches++;
                    end
                    if (out_data.price_rate !== want.price_rate) begin
                        $error("price_rate: expected %h, got %h",
                               want.price_rate, out_data.price_rate);
                        mismatches++;
                    end
                    if (out_data.rate_average !== want.rate_average) begin
                        $error("rate_average: expected %h, got %h",
                               want.rate_average, out_data.rate_average);
                        mismatches++;
                    end
                    if (out_data.divide_fault !== want.divide_fault) begin
                        $error("divide_fault: expected %b, got %b",
                               want.divide_fault, out_data.divide_fault);
                        mismatches++;
                    end
                    if (out_data.series_end !== want.series_end) begin
                        $error("series_end: expected %b, got %b",
                               want.series_end, out_data.series_end);
                        mismatches++;
                    end
                end
            end
            if (hold_request && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [CFG_W-1:0] windows [NUM_PHASES];
        int               p;
        int               i;
        windows = '{3, 64, 0, 127, 1, 2, 8, 33, 64, 5, 96, 17};
        windows[11] = $urandom_range(127);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first bar, zero previous price, drop to zero, saturation, lone bars
        push_bar('0, '0, '0, '0, 1'b0);
        push_bar(PRICE_MAX, PRICE_MAX, PRICE_MAX, PRICE_MAX, 1'b0);
        push_bar('0, '0, '0, '0, 1'b0);
        push_bar(1, 1, 1, 1, 1'b0);
        push_bar(PRICE_MAX, PRICE_MAX, PRICE_MAX, PRICE_MAX, 1'b1);
        push_bar(PRICE_MAX, '0, '0, '0, 1'b1);
        push_bar('0, PRICE_MAX, '0, '0, 1'b1);
        push_bar(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
        push_bar(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
        push_bar(32'h0001_8000, 32'h0001_8000, 32'h0001_8000, 32'h0001_8000, 1'b0);
        push_bar(32'h0000_8000, 32'h0002_0000, 32'h0000_4000, 32'h0000_C000, 1'b0);
        push_bar('0, '0, PRICE_MAX, '0, 1'b0);
        push_bar('0, '0, '0, PRICE_MAX, 1'b1);
        push_bar(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0);
        push_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC, 1'b1);
        wait_idle();

        for (p = 0; p < NUM_PHASES; p++) begin
            write_window(windows[p]);
            if (p == 4) begin
                send_idle_pct <= 54;
                recv_idle_pct <= 15;
            end else if (p == 8) begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
                hold_request  <= 1'b1;
            end
            @(posedge clk);
            for (i = 0; i < BARS_PER_PHASE; i++)
                queue_random_bar();
            wait_idle();
        end

        repeat (250) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
